// ===== rtl/bab_pkg.sv =====
`default_nettype none

package bab_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_BEACON_LEN  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_TYPE   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPANY_ID  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BEACON_TYPE = 8'd3;

    localparam logic [5:0]  RST_BEACON_LEN  = 6'd26;
    localparam logic [7:0]  RST_DATA_TYPE   = 8'hff;
    localparam logic [15:0] RST_COMPANY_ID  = 16'h004c;
    localparam logic [7:0]  RST_BEACON_TYPE = 8'h02;

    localparam logic [7:0] MIN_BEACON_LEN = 8'd4;

    typedef logic [1:0] cmp_step_t;

    localparam cmp_step_t STEP_DATA_TYPE   = 2'd0;
    localparam cmp_step_t STEP_COMPANY_LO  = 2'd1;
    localparam cmp_step_t STEP_COMPANY_HI  = 2'd2;
    localparam cmp_step_t STEP_BEACON_TYPE = 2'd3;

    typedef struct packed {
        logic [5:0]  beacon_field_length;
        logic [7:0]  data_type;
        logic [15:0] company_id;
        logic [7:0]  beacon_type;
    } cfg_t;

    typedef struct packed {
        logic found;
        logic corrupt;
    } verdict_t;

    function automatic logic [7:0] expected_byte(input cfg_t cfg, input cmp_step_t step);
        logic [7:0] val;
        val = cfg.beacon_type;
        case (step)
            STEP_DATA_TYPE:   val = cfg.data_type;
            STEP_COMPANY_LO:  val = cfg.company_id[7:0];
            STEP_COMPANY_HI:  val = cfg.company_id[15:8];
            default:          val = cfg.beacon_type;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bab_parser.sv =====
`default_nettype none

module bab_parser #(
    parameter int unsigned PACKET_BYTES  = 40,
    parameter int unsigned DATA_START    = 9,
    parameter int unsigned MAX_FIELD_LEN = 39
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step_en,
    input  wire logic [7:0]      pdu_byte,
    input  wire logic            last_byte,
    input  wire bab_pkg::cfg_t   cfg,
    output bab_pkg::verdict_t    verdict
);

    localparam int unsigned POS_W = $clog2(PACKET_BYTES + 1);
    localparam int unsigned NFS_W = $clog2(PACKET_BYTES + MAX_FIELD_LEN + 1);
    localparam int unsigned SUM_W = ((NFS_W > 8) ? NFS_W : 8) + 1;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [NFS_W-1:0]   nfs_reg, nfs_next;
    bab_pkg::cmp_step_t cmp_reg, cmp_next;
    logic               cand_reg, cand_next;
    logic               decided_reg, decided_next;
    logic               found_reg, found_next;
    logic               corrupt_reg, corrupt_next;

    logic               in_window;
    logic [SUM_W-1:0]   field_end;

    assign in_window = (pos_reg < POS_W'(PACKET_BYTES));
    assign field_end = SUM_W'(pos_reg) + SUM_W'(pdu_byte) + SUM_W'(1);

    always_comb begin
        pos_next     = pos_reg;
        nfs_next     = nfs_reg;
        cmp_next     = cmp_reg;
        cand_next    = cand_reg;
        decided_next = decided_reg;
        found_next   = found_reg;
        corrupt_next = corrupt_reg;
        if (!decided_reg && in_window) begin
            if (cand_reg) begin
                if (pdu_byte != bab_pkg::expected_byte(cfg, cmp_reg)) begin
                    cand_next = 1'b0;
                end else if (cmp_reg == bab_pkg::STEP_BEACON_TYPE) begin
                    cand_next    = 1'b0;
                    found_next   = 1'b1;
                    decided_next = 1'b1;
                end else begin
                    cmp_next = cmp_reg + bab_pkg::cmp_step_t'(1);
                end
            end else if (NFS_W'(pos_reg) == nfs_reg) begin
                if (pdu_byte > 8'(MAX_FIELD_LEN)) begin
                    corrupt_next = 1'b1;
                    decided_next = 1'b1;
                end else begin
                    if ((pdu_byte == 8'(cfg.beacon_field_length))
                        && (pdu_byte >= bab_pkg::MIN_BEACON_LEN)) begin
                        cand_next = 1'b1;
                        cmp_next  = bab_pkg::STEP_DATA_TYPE;
                    end
                    nfs_next = field_end[NFS_W-1:0];
                end
            end
        end
        if (in_window) begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    assign verdict.found   = found_next;
    assign verdict.corrupt = corrupt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && last_byte)) begin
            pos_reg     <= '0;
            nfs_reg     <= NFS_W'(DATA_START);
            cmp_reg     <= bab_pkg::STEP_DATA_TYPE;
            cand_reg    <= 1'b0;
            decided_reg <= 1'b0;
            found_reg   <= 1'b0;
            corrupt_reg <= 1'b0;
        end else if (step_en) begin
            pos_reg     <= pos_next;
            nfs_reg     <= nfs_next;
            cmp_reg     <= cmp_next;
            cand_reg    <= cand_next;
            decided_reg <= decided_next;
            found_reg   <= found_next;
            corrupt_reg <= corrupt_next;
        end
    end

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(found_reg && corrupt_reg))
        else $error("found and corrupt both set");

    a_cand_undecided: assert property (@(posedge aclk) disable iff (!aresetn)
        cand_reg |-> !decided_reg)
        else $error("candidate open after a decision");

    a_decided_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        decided_reg == (found_reg || corrupt_reg))
        else $error("decision state disagrees with flags");

    a_packet_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && last_byte) |=> (pos_reg == '0 && !decided_reg && !cand_reg))
        else $error("walk state not cleared after last byte");

endmodule

`default_nettype wire

// ===== rtl/ble_adv_beacon_filter_top.sv =====
// Latency: a verdict word appears at the clock edge after the last byte is accepted,
// or later while an earlier verdict word waits in the verdict register.
// Throughput: one byte per cycle whenever the verdict register is free; the input register feeds the
// walk logic and the verdict register, which advance together.
// Reset (aresetn low, synchronous) empties both registers, clears the walk state and
// restores the match registers to their defaults.
`default_nettype none

module ble_adv_beacon_filter_top #(
    parameter int unsigned PACKET_BYTES  = 40,
    parameter int unsigned DATA_START    = 9,
    parameter int unsigned MAX_FIELD_LEN = 39
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] pdu_byte
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             m_tdata,   // [0] beacon_found, [1] length_corrupt
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bab_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bab_pkg::CFG_DATA_W-1:0]    cfg_data
);

    bab_pkg::cfg_t     cfg_reg;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    bab_pkg::verdict_t out_reg;
    bab_pkg::verdict_t verdict;
    logic              advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.beacon_field_length <= bab_pkg::RST_BEACON_LEN;
            cfg_reg.data_type           <= bab_pkg::RST_DATA_TYPE;
            cfg_reg.company_id          <= bab_pkg::RST_COMPANY_ID;
            cfg_reg.beacon_type         <= bab_pkg::RST_BEACON_TYPE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bab_pkg::CFG_BEACON_LEN:  cfg_reg.beacon_field_length <= cfg_data[5:0];
                bab_pkg::CFG_DATA_TYPE:   cfg_reg.data_type           <= cfg_data[7:0];
                bab_pkg::CFG_COMPANY_ID:  cfg_reg.company_id          <= cfg_data;
                bab_pkg::CFG_BEACON_TYPE: cfg_reg.beacon_type         <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    bab_parser #(
        .PACKET_BYTES  (PACKET_BYTES),
        .DATA_START    (DATA_START),
        .MAX_FIELD_LEN (MAX_FIELD_LEN)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .pdu_byte  (in_byte_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg_reg),
        .verdict   (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_last_reg;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.corrupt, out_reg.found};

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input word dropped while stalled");

    a_out_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.found && out_reg.corrupt))
        else $error("verdict reports found and corrupt together");

    a_verdict_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> out_valid_reg)
        else $error("verdict word not presented after last byte");

endmodule

`default_nettype wire
